// ===== rtl/imhdk_pkg.sv =====
// Shared types and constants for the indexed min-heap with decrease-key.
package imhdk_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int KEY_WIDTH  = 32;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam int IDX_W      = NODE_W + 2;
    localparam int HOPS_W     = 16;
    localparam int ACT_W      = 2;
    localparam int STAT_W     = 3;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    localparam logic [ACT_W-1:0] ACT_PUSH      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP       = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR_ALT = 2'd3;

    localparam logic [STAT_W-1:0] ST_INSERTED       = 3'd0;
    localparam logic [STAT_W-1:0] ST_LOWERED        = 3'd1;
    localparam logic [STAT_W-1:0] ST_IGN_FINISHED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_IGN_NOT_BETTER = 3'd3;
    localparam logic [STAT_W-1:0] ST_POPPED         = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY          = 3'd5;
    localparam logic [STAT_W-1:0] ST_CLEARED        = 3'd6;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_REJECT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PT_UNSEEN   = 2'd0,
        PT_QUEUED   = 2'd1,
        PT_FINISHED = 2'd2
    } t_pos_tag;

    typedef struct packed {
        t_pos_tag            tag;
        logic [NODE_W-1:0]   slot;
    } t_pos;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic [HOPS_W-1:0]    hops;
        logic [NODE_W-1:0]    node;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
    localparam int POS_W   = $bits(t_pos);

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic [NODE_W-1:0]    node_id;
        logic [KEY_WIDTH-1:0] key;
        logic [HOPS_W-1:0]    hop_count;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [NODE_W-1:0]    out_node;
        logic [KEY_WIDTH-1:0] out_key;
        logic [HOPS_W-1:0]    out_hops;
        logic [CNT_W-1:0]     heap_count;
    } t_out;

    typedef struct packed {
        t_op                  op;
        logic [NODE_W-1:0]    node;
        logic [KEY_WIDTH-1:0] key;
        logic [HOPS_W-1:0]    hops;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_beat;

endpackage

// ===== rtl/indexed_min_heap_decrease_key.sv =====
// Top level of the indexed binary min-heap with decrease-key.
//
//   beat       direction  handshake              payload
//   -------    ---------  ---------------------  ---------------------
//   command    in         i_in_valid / o_in_stall   imhdk_pkg::t_in
//   result     out        o_out_valid / i_out_stall imhdk_pkg::t_out
//
// Sequence: a push climbs one level per sift step, a decrease key first checks
//   the old key, a pop sinks one level per sift step, a clear runs the position
//   sweep. Sift steps are set by one read port on the entry memory, read data
//   registered.
// Reset: a sweep writes "unseen" to every position word, with o_in_stall
//   high; a clear beat runs the same sweep.
// Stalls: a two-entry command queue takes beats while the heap sequencer
//   works; the result register holds one finished beat under i_out_stall.
module indexed_min_heap_decrease_key (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  imhdk_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output imhdk_pkg::t_out o_out
);

    imhdk_pkg::t_cmd_beat cmd_beat;
    logic                 cmd_pop;
    logic                 init_busy;

    // front: decode and queue
    imhdk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_hold     (init_busy),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd_beat),
        .i_cmd_pop  (cmd_pop)
    );

    // back: heap sequencer and result register
    imhdk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_beat),
        .o_cmd_pop   (cmd_pop),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

`ifndef ASSERT_OFF
    // count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out.heap_count) <= imhdk_pkg::NODE_COUNT))
        else $error("heap count above capacity");

    // only pops carry entry payload
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != imhdk_pkg::ST_POPPED)
        |-> (o_out.out_node == '0 && o_out.out_key == '0 && o_out.out_hops == '0))
        else $error("payload on non-pop result");

    // clear and empty leave no entries
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status == imhdk_pkg::ST_CLEARED
                         || o_out.status == imhdk_pkg::ST_EMPTY))
        |-> (o_out.heap_count == '0))
        else $error("nonzero count after clear or empty pop");
`endif

endmodule

// ===== rtl/imhdk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module imhdk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/imhdk_front.sv =====
// Front end: takes input beats, classifies the action and queues commands.
module imhdk_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  imhdk_pkg::t_in    i_in,
    input  logic              i_hold,
    output logic              o_in_stall,
    output imhdk_pkg::t_cmd_beat o_cmd,
    input  logic              i_cmd_pop
);

    imhdk_pkg::t_cmd               r_q [imhdk_pkg::QDEPTH];
    logic [imhdk_pkg::QPTR_W-1:0]  r_wp, n_wp;
    logic [imhdk_pkg::QPTR_W-1:0]  r_rp, n_rp;
    logic [imhdk_pkg::QCNT_W-1:0]  r_cnt, n_cnt;
    imhdk_pkg::t_cmd               cls;
    logic                          push;
    logic                          pop;

    // decode action; both upper codes mean clear
    always_comb begin
        cls.node = i_in.node_id;
        cls.key  = i_in.key;
        cls.hops = i_in.hop_count;
        if (i_in.action == imhdk_pkg::ACT_CLEAR || i_in.action == imhdk_pkg::ACT_CLEAR_ALT) begin
            cls.op = imhdk_pkg::OP_CLEAR;
        end else if (i_in.action == imhdk_pkg::ACT_POP) begin
            cls.op = imhdk_pkg::OP_POP;
        end else if (32'(i_in.node_id) >= imhdk_pkg::NODE_COUNT) begin
            cls.op = imhdk_pkg::OP_REJECT;
        end else begin
            cls.op = imhdk_pkg::OP_PUSH;
        end
    end

    assign o_in_stall = (r_cnt == imhdk_pkg::QCNT_W'(imhdk_pkg::QDEPTH)) || i_hold;
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_cmd_pop && (r_cnt != '0);

    assign o_cmd.valid = (r_cnt != '0);
    assign o_cmd.cmd   = r_q[r_rp];

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + imhdk_pkg::QCNT_W'(push) - imhdk_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

// ===== rtl/imhdk_back.sv =====
// Back end: heap sequencer over the entry and position memories.
module imhdk_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  imhdk_pkg::t_cmd_beat i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_init_busy,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output imhdk_pkg::t_out      o_out
);

    typedef enum logic [11:0] {
        S_SWEEP  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_P_POS  = 12'b0000_0000_0100,
        S_P_KEY  = 12'b0000_0000_1000,
        S_U_RD   = 12'b0000_0001_0000,
        S_U_CMP  = 12'b0000_0010_0000,
        S_O_TOP  = 12'b0000_0100_0000,
        S_O_LAST = 12'b0000_1000_0000,
        S_D_L    = 12'b0001_0000_0000,
        S_D_R    = 12'b0010_0000_0000,
        S_D_CMP  = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    localparam int NW = imhdk_pkg::NODE_W;
    localparam int CW = imhdk_pkg::CNT_W;
    localparam int XW = imhdk_pkg::IDX_W;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_size, n_size;
    logic [CW-1:0]      r_idx, n_idx;
    logic [NW-1:0]      r_slot, n_slot;
    imhdk_pkg::t_entry  r_ent, n_ent;
    imhdk_pkg::t_entry  r_left, n_left;
    logic               r_has_right, n_has_right;
    logic               r_clr_resp, n_clr_resp;
    imhdk_pkg::t_out    r_res, n_res;
    logic               r_out_valid, n_out_valid;
    imhdk_pkg::t_out    r_out, n_out;

    logic                         h_we;
    logic [NW-1:0]                h_waddr, h_raddr;
    imhdk_pkg::t_entry            h_wdata, h_rdata;
    logic [imhdk_pkg::ENTRY_W-1:0] h_rraw;
    logic                         p_we;
    logic [NW-1:0]                p_waddr, p_raddr;
    imhdk_pkg::t_pos              p_wdata, p_rdata;
    logic [imhdk_pkg::POS_W-1:0]  p_rraw;

    logic [XW-1:0]      left_idx, right_idx, size_x;
    logic [NW-1:0]      parent;
    imhdk_pkg::t_entry  pick;
    logic [NW-1:0]      pick_idx;
    logic               out_free;

    imhdk_ram #(.WIDTH(imhdk_pkg::ENTRY_W), .DEPTH(imhdk_pkg::NODE_COUNT)) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rraw)
    );

    imhdk_ram #(.WIDTH(imhdk_pkg::POS_W), .DEPTH(imhdk_pkg::NODE_COUNT)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rraw)
    );

    assign h_rdata   = imhdk_pkg::t_entry'(h_rraw);
    assign p_rdata   = imhdk_pkg::t_pos'(p_rraw);
    assign left_idx  = XW'({r_slot, 1'b1});
    assign right_idx = left_idx + 1'b1;
    assign size_x    = XW'(r_size);
    assign parent    = (r_slot - 1'b1) >> 1;
    assign out_free  = !r_out_valid || !i_out_stall;

    // right child wins a tie
    always_comb begin
        if (r_has_right && !(r_left.key < h_rdata.key)) begin
            pick     = h_rdata;
            pick_idx = right_idx[NW-1:0];
        end else begin
            pick     = r_left;
            pick_idx = left_idx[NW-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_ent       = r_ent;
        n_left      = r_left;
        n_has_right = r_has_right;
        n_clr_resp  = r_clr_resp;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd_pop   = 1'b0;
        h_we        = 1'b0;
        h_waddr     = r_slot;
        h_wdata     = r_ent;
        h_raddr     = '0;
        p_we        = 1'b0;
        p_waddr     = r_ent.node;
        p_wdata     = '{tag: imhdk_pkg::PT_QUEUED, slot: r_slot};
        p_raddr     = i_cmd.cmd.node;

        unique case (r_state)
            S_SWEEP: begin
                p_we    = 1'b1;
                p_waddr = r_idx[NW-1:0];
                p_wdata = '{tag: imhdk_pkg::PT_UNSEEN, slot: '0};
                n_idx   = r_idx + 1'b1;
                if (r_idx == CW'(imhdk_pkg::NODE_COUNT - 1)) begin
                    n_state = r_clr_resp ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    o_cmd_pop  = 1'b1;
                    n_res      = '0;
                    n_ent.key  = i_cmd.cmd.key;
                    n_ent.hops = i_cmd.cmd.hops;
                    n_ent.node = i_cmd.cmd.node;
                    unique case (i_cmd.cmd.op)
                        imhdk_pkg::OP_PUSH: begin
                            n_state = S_P_POS;
                        end
                        imhdk_pkg::OP_POP: begin
                            if (r_size == '0) begin
                                n_res.status = imhdk_pkg::ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_O_TOP;
                            end
                        end
                        imhdk_pkg::OP_CLEAR: begin
                            n_size       = '0;
                            n_idx        = '0;
                            n_clr_resp   = 1'b1;
                            n_res.status = imhdk_pkg::ST_CLEARED;
                            n_state      = S_SWEEP;
                        end
                        imhdk_pkg::OP_REJECT: begin
                            n_res.status = imhdk_pkg::ST_IGN_FINISHED;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_P_POS: begin
                if (p_rdata.tag == imhdk_pkg::PT_FINISHED) begin
                    n_res.status = imhdk_pkg::ST_IGN_FINISHED;
                    n_state      = S_DONE;
                end else if (p_rdata.tag == imhdk_pkg::PT_QUEUED
                             && XW'(p_rdata.slot) < size_x) begin
                    h_raddr = p_rdata.slot;
                    n_slot  = p_rdata.slot;
                    n_state = S_P_KEY;
                end else begin
                    n_res.status = imhdk_pkg::ST_INSERTED;
                    if (r_size < CW'(imhdk_pkg::NODE_COUNT)) begin
                        n_slot  = r_size[NW-1:0];
                        n_size  = r_size + 1'b1;
                        n_state = S_U_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_P_KEY: begin
                if (r_ent.key >= h_rdata.key) begin
                    n_res.status = imhdk_pkg::ST_IGN_NOT_BETTER;
                    n_state      = S_DONE;
                end else begin
                    n_res.status = imhdk_pkg::ST_LOWERED;
                    n_state      = S_U_RD;
                end
            end
            S_U_RD: begin
                if (r_slot == '0) begin
                    h_we    = 1'b1;
                    p_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    h_raddr = parent;
                    n_state = S_U_CMP;
                end
            end
            S_U_CMP: begin
                h_we = 1'b1;
                p_we = 1'b1;
                if (r_ent.key < h_rdata.key) begin
                    h_wdata = h_rdata;
                    p_waddr = h_rdata.node;
                    n_slot  = parent;
                    n_state = S_U_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_O_TOP: begin
                n_res.status   = imhdk_pkg::ST_POPPED;
                n_res.out_node = h_rdata.node;
                n_res.out_key  = h_rdata.key;
                n_res.out_hops = h_rdata.hops;
                p_we    = (32'(h_rdata.node) < imhdk_pkg::NODE_COUNT);
                p_waddr = h_rdata.node;
                p_wdata = '{tag: imhdk_pkg::PT_FINISHED, slot: '0};
                n_size  = r_size - 1'b1;
                if (r_size == CW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    h_raddr = n_size[NW-1:0];
                    n_state = S_O_LAST;
                end
            end
            S_O_LAST: begin
                n_ent   = h_rdata;
                n_slot  = '0;
                n_state = S_D_L;
            end
            S_D_L: begin
                if (left_idx >= size_x) begin
                    h_we    = 1'b1;
                    p_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    h_raddr = left_idx[NW-1:0];
                    n_state = S_D_R;
                end
            end
            S_D_R: begin
                n_left      = h_rdata;
                n_has_right = (right_idx < size_x);
                h_raddr     = right_idx[NW-1:0];
                n_state     = S_D_CMP;
            end
            S_D_CMP: begin
                h_we = 1'b1;
                p_we = 1'b1;
                if (pick.key < r_ent.key) begin
                    h_wdata = pick;
                    p_waddr = pick.node;
                    n_slot  = pick_idx;
                    n_state = S_D_L;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out            = r_res;
                    n_out.heap_count = r_size;
                    n_out_valid      = 1'b1;
                    n_clr_resp       = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_size      <= '0;
            r_idx       <= '0;
            r_clr_resp  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_idx       <= n_idx;
            r_clr_resp  <= n_clr_resp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_ent       <= n_ent;
        r_left      <= n_left;
        r_has_right <= n_has_right;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign o_init_busy = (r_state == S_SWEEP) && !r_clr_resp;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== dv/heap_checker.sv =====
// Checker for the indexed min-heap: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module heap_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  imhdk_pkg::t_in  i_in,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  imhdk_pkg::t_out i_out,
    output int              o_fail_count,
    output int              o_pending
);
    import imhdk_pkg::*;

    // node position codes
    localparam int POS_FREE = -1;
    localparam int POS_DONE = -2;

    t_entry heap_mem [NODE_COUNT];
    int     node_slot [NODE_COUNT];
    int     heap_len;
    t_out   result_fifo [$];

    assign o_pending = result_fifo.size();

    function automatic void put(int slot, t_entry e);
        heap_mem[slot] = e;
        node_slot[e.node] = slot;
    endfunction

    function automatic void wipe();
        foreach (node_slot[i]) node_slot[i] = POS_FREE;
        heap_len = 0;
    endfunction

    function automatic void climb(int slot, t_entry e);
        int parent;
        while (slot > 0) begin
            parent = (slot - 1) / 2;
            if (e.key < heap_mem[parent].key) begin
                put(slot, heap_mem[parent]);
                slot = parent;
            end else begin
                break;
            end
        end
        put(slot, e);
    endfunction

    function automatic void sink(t_entry e);
        int slot;
        int left;
        int pick;
        slot = 0;
        forever begin
            left = 2 * slot + 1;
            if (left >= heap_len) break;
            pick = left;
            // equal children: right one wins
            if (left + 1 < heap_len && !(heap_mem[left].key < heap_mem[left + 1].key))
                pick = left + 1;
            if (heap_mem[pick].key < e.key) begin
                put(slot, heap_mem[pick]);
                slot = pick;
            end else begin
                break;
            end
        end
        put(slot, e);
    endfunction

    function automatic t_out predict_heap(t_in c);
        t_out   r;
        t_entry e;
        int     pos;
        r = '0;
        if (c.action[1]) begin
            wipe();
            r.status = ST_CLEARED;
        end else if (c.action == ACT_PUSH) begin
            pos = node_slot[c.node_id];
            e.key = c.key;
            e.hops = c.hop_count;
            e.node = c.node_id;
            if (pos == POS_DONE) begin
                r.status = ST_IGN_FINISHED;
            end else if (pos == POS_FREE || pos >= heap_len) begin
                if (heap_len < NODE_COUNT) begin
                    heap_len++;
                    climb(heap_len - 1, e);
                end
                r.status = ST_INSERTED;
            end else if (c.key >= heap_mem[pos].key) begin
                r.status = ST_IGN_NOT_BETTER;
            end else begin
                climb(pos, e);
                r.status = ST_LOWERED;
            end
        end else begin
            if (heap_len == 0) begin
                r.status = ST_EMPTY;
            end else begin
                e = heap_mem[0];
                node_slot[e.node] = POS_DONE;
                heap_len--;
                if (heap_len > 0) sink(heap_mem[heap_len]);
                r.status = ST_POPPED;
                r.out_node = e.node;
                r.out_key = e.key;
                r.out_hops = e.hops;
            end
        end
        r.heap_count = heap_len[CNT_W-1:0];
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        wipe();
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && i_in_valid && !i_in_stall)
            result_fifo.push_back(predict_heap(i_in));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (result_fifo.size() == 0) begin
                $error("result beat with nothing expected");
                o_fail_count++;
            end else begin
                want = result_fifo.pop_front();
                if (i_out.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, i_out.status);
                    o_fail_count++;
                end
                if (i_out.out_node !== want.out_node) begin
                    $error("out_node exp %0d got %0d", want.out_node, i_out.out_node);
                    o_fail_count++;
                end
                if (i_out.out_key !== want.out_key) begin
                    $error("out_key exp %0h got %0h", want.out_key, i_out.out_key);
                    o_fail_count++;
                end
                if (i_out.out_hops !== want.out_hops) begin
                    $error("out_hops exp %0d got %0d", want.out_hops, i_out.out_hops);
                    o_fail_count++;
                end
                if (i_out.heap_count !== want.heap_count) begin
                    $error("heap_count exp %0d got %0d", want.heap_count,
                           i_out.heap_count);
                    o_fail_count++;
                end
            end
        end
    end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top: stimulus and verdict for the indexed min-heap with decrease-key.
`timescale 1ns / 100ps
module tb_top;
    import imhdk_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_beat;
    logic out_valid;
    logic out_stall;
    t_out out_beat;
    int   fail_count;
    int   pending;
    bit   quiet;     // no idling in the closing stretch

    indexed_min_heap_decrease_key u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    heap_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net: the slowest run is ~1750 clears, each a full position sweep, plus stalls.
    initial begin
        #60_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Receiver stall: random bursts, off during the closing stretch.
    initial begin
        int n;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 6);
                out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                out_stall = 1'b0;
            end
        end
    end

    // Drive one beat at the falling edge and hold it until accepted.
    task automatic send_beat(logic [ACT_W-1:0] act, int node, logic [31:0] k,
                             logic [HOPS_W-1:0] h);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_beat.action = act;
        in_beat.node_id = node[NODE_W-1:0];
        in_beat.key = k;
        in_beat.hop_count = h;
        in_valid = 1'b1;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    // Bias keys toward a small range so ties and decreases happen often.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 15);
            default: return $urandom_range(0, 4000);
        endcase
    endfunction

    task automatic wait_drain();
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int r;
        int lim;
        quiet = 1'b0;
        in_valid = 1'b0;
        in_beat = '0;
        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty pop, ties, decrease key, finished node, extremes.
        send_beat(ACT_POP, 0, 0, 0);
        send_beat(ACT_PUSH, 1023, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(ACT_PUSH, 0, 32'd0, 16'h0000);
        send_beat(ACT_PUSH, 5, 32'd100, 16'h5555);
        send_beat(ACT_PUSH, 6, 32'd100, 16'hAAAA);  // tie with node 5
        send_beat(ACT_PUSH, 7, 32'd100, 16'd7);     // tie among children
        send_beat(ACT_PUSH, 5, 32'd100, 16'd1);     // equal key: not better
        send_beat(ACT_PUSH, 6, 32'd200, 16'd1);     // larger key: not better
        send_beat(ACT_PUSH, 1023, 32'd50, 16'd9);   // key lowered
        send_beat(ACT_PUSH, 682, 32'hAAAA_AAAA, 16'd3);
        send_beat(ACT_PUSH, 341, 32'h5555_5555, 16'd4);
        send_beat(ACT_POP, 0, 0, 0);
        send_beat(ACT_PUSH, 0, 32'd1, 16'd1);        // node finished
        repeat (7) send_beat(ACT_POP, 0, 0, 0);      // drain past empty
        send_beat(ACT_PUSH, 9, 32'd3, 16'd3);
        send_beat(ACT_CLEAR_ALT, 0, 0, 0);           // action 3 clears too
        send_beat(ACT_PUSH, 0, 32'd8, 16'd8);        // unseen again after clear
        send_beat(ACT_CLEAR, 0, 0, 0);

        // Pause until every outstanding result is back.
        wait_drain();

        // Random: search-like phases, mostly pushes and pops on a node window.
        for (int i = 0; i < 1750; i++) begin
            if (i == 1550) quiet = 1'b1;
            if (i % 300 == 0) lim = (i % 600 == 0) ? 1023 : 31;
            r = $urandom_range(0, 99);
            if (r < 1)
                send_beat($urandom_range(0, 1) ? ACT_CLEAR : ACT_CLEAR_ALT, $urandom,
                          $urandom, HOPS_W'($urandom));
            else if (r < 62)
                send_beat(ACT_PUSH, $urandom_range(0, lim), pick_key(),
                          HOPS_W'($urandom));
            else
                send_beat(ACT_POP, $urandom, $urandom, HOPS_W'($urandom));
        end

        wait_drain();
        repeat (50) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
